>>> rtl/imgup_pkg.sv
// Shared constants, types and arithmetic helpers of the image upscale interpolator.
package imgup_pkg;

  localparam int IMG_WIDTH  = 64;
  localparam int IMG_HEIGHT = 64;

  localparam int COORD_W = 9;
  localparam int PIX_W   = 8;
  localparam int SCALE_W = 4;
  localparam int MODE_W  = 2;
  localparam int FRAC_W  = 3;
  localparam int WGT_W   = 7;
  localparam int NUM_W   = 14;

  localparam int COL_W = (IMG_WIDTH  > 1) ? $clog2(IMG_WIDTH)  : 1;
  localparam int ROW_W = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;

  // Four banks split by column parity and row parity.
  localparam int BANK_COLS  = (IMG_WIDTH + 1) / 2;
  localparam int BANK_ROWS  = (IMG_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 25;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_BILINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HORIZ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VERT     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MIDPOINT = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd4;
  localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_BILINEAR;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } rd_req_t;

  // Upper left, upper right, lower left, lower right neighbors.
  typedef struct packed {
    logic [PIX_W-1:0] ul;
    logic [PIX_W-1:0] ur;
    logic [PIX_W-1:0] ll;
    logic [PIX_W-1:0] lr;
  } quad_t;

  // Zero acts as 1 and anything above 8 saturates to 8.
  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
    logic [SCALE_W-1:0] r;
    if (s == '0) r = 4'd1;
    else if (s > 4'd8) r = 4'd8;
    else r = s;
    return r;
  endfunction

  // ceil(2^24 / d) for d = 1..8.
  function automatic logic [RECIP_W-1:0] recip_lin(input logic [SCALE_W-1:0] d);
    logic [RECIP_W-1:0] m;
    unique case (d)
      4'd2:    m = 25'd8388608;
      4'd3:    m = 25'd5592406;
      4'd4:    m = 25'd4194304;
      4'd5:    m = 25'd3355444;
      4'd6:    m = 25'd2796203;
      4'd7:    m = 25'd2396746;
      4'd8:    m = 25'd2097152;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

  // ceil(2^24 / (s * s)) for s = 1..8.
  function automatic logic [RECIP_W-1:0] recip_sq(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] m;
    unique case (s)
      4'd2:    m = 25'd4194304;
      4'd3:    m = 25'd1864136;
      4'd4:    m = 25'd1048576;
      4'd5:    m = 25'd671089;
      4'd6:    m = 25'd466034;
      4'd7:    m = 25'd342393;
      4'd8:    m = 25'd262144;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

  // Floor division by reciprocal multiplication. Exact while n * d < 2^24.
  function automatic logic [NUM_W-1:0] div_recip(input logic [NUM_W-1:0] n,
                                                 input logic [RECIP_W-1:0] m);
    logic [NUM_W+RECIP_W-1:0] prod;
    prod = (NUM_W+RECIP_W)'(n) * (NUM_W+RECIP_W)'(m);
    return prod[RECIP_SHIFT +: NUM_W];
  endfunction

endpackage

>>> rtl/imgup_ram.sv
// Generic single-port synchronous RAM with registered read data.
module imgup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/imgup_banks.sv
// Four parity-banked pixel memories that return a 2x2 neighborhood in one read.
module imgup_banks (
  input  logic              clk,
  input  imgup_pkg::wr_req_t wr,
  input  imgup_pkg::rd_req_t rd,
  output imgup_pkg::quad_t   quad
);
  import imgup_pkg::*;

  localparam int FULL_AW = COL_W + ROW_W + 2;

  logic [PIX_W-1:0] rdat [4];
  logic             cpar_r;
  logic             rpar_r;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = ((b % 2) == 1);
    localparam logic RP = ((b / 2) == 1);

    logic [COL_W:0]       c_sel;
    logic [ROW_W:0]       r_sel;
    logic [FULL_AW-1:0]   raddr_full;
    logic [FULL_AW-1:0]   waddr_full;
    logic                 we;
    logic                 en;
    logic [BANK_AW-1:0]   addr;

    // Each bank serves the neighbor whose column and row parity match it.
    always_comb begin
      c_sel = (rd.col[0] == CP) ? (COL_W+1)'(rd.col) : (COL_W+1)'(rd.col) + (COL_W+1)'(1);
      r_sel = (rd.row[0] == RP) ? (ROW_W+1)'(rd.row) : (ROW_W+1)'(rd.row) + (ROW_W+1)'(1);
      raddr_full = FULL_AW'(r_sel >> 1) * FULL_AW'(BANK_COLS) + FULL_AW'(c_sel >> 1);
      waddr_full = FULL_AW'(wr.row >> 1) * FULL_AW'(BANK_COLS) + FULL_AW'(wr.col >> 1);
      we   = wr.en && (wr.col[0] == CP) && (wr.row[0] == RP);
      en   = we || rd.en;
      addr = wr.en ? waddr_full[BANK_AW-1:0] : raddr_full[BANK_AW-1:0];
    end

    imgup_ram #(
      .WIDTH(PIX_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .en   (en),
      .we   (we),
      .addr (addr),
      .wdata(wr.data),
      .rdata(rdat[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      cpar_r <= rd.col[0];
      rpar_r <= rd.row[0];
    end
  end

  always_comb begin
    quad.ul = rdat[{rpar_r, cpar_r}];
    quad.ur = rdat[{rpar_r, ~cpar_r}];
    quad.ll = rdat[{~rpar_r, cpar_r}];
    quad.lr = rdat[{~rpar_r, ~cpar_r}];
  end

endmodule

>>> rtl/image_upscale_interpolator.sv
// Top level of the image upscale interpolator: handshakes, sequencer and arithmetic.
// A load item is written into the banks at its accepting edge, and loads can follow each other
// every cycle while no query is in progress. An in-range query passes the coordinate divide,
// the bank read, weighting, summing and the final divide in that order; out_tvalid rises and
// in_tready returns at the same edge. A flagged query skips the memory and goes straight to
// the final divide. A result not yet taken holds the next query in its last stage until taken.
// Reset clears the sequencer, the output valid flag, scale (to 4) and mode (to bilinear);
// the pixel memories are not cleared and hold undefined data until loaded.
module image_upscale_interpolator (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input item.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata from bit 0 up: x[8:0], y[17:9], pixel_in[25:18], zero padding[31:26].
  input  logic [imgup_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: opcode (0 load, 1 query).
  input  logic                               in_tuser,
  // Result item.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata from bit 0 up: pixel_out[7:0].
  output logic [imgup_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser: bad_coord.
  output logic                               out_tuser,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [imgup_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [imgup_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import imgup_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_FRAC = 3'd2;
  localparam logic [2:0] ST_WGT  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_NORM = 3'd5;

  // Wide enough for 512 columns times a scale of 8.
  localparam int LIM_W = COORD_W + SCALE_W;
  localparam int SUM_W = NUM_W + 3;

  logic [2:0]          state_r, state_nxt;
  logic [SCALE_W-1:0]  scale_r;
  logic [MODE_W-1:0]   mode_r;
  logic [COORD_W-1:0]  x_r, x_nxt;
  logic [COORD_W-1:0]  y_r, y_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic                bad_r, bad_nxt;
  logic [FRAC_W-1:0]   fx_r, fx_nxt;
  logic [FRAC_W-1:0]   fy_r, fy_nxt;
  quad_t               quad_r, quad_nxt;
  logic [WGT_W-1:0]    w_r [4];
  logic [WGT_W-1:0]    w_nxt [4];
  logic [RECIP_W-1:0]  m_r, m_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]    out_pix_r, out_pix_nxt;
  logic                out_bad_r, out_bad_nxt;

  logic [COORD_W-1:0]  in_x;
  logic [COORD_W-1:0]  in_y;
  logic [PIX_W-1:0]    in_pix;
  logic                in_acc;
  logic [SCALE_W-1:0]  s_eff;
  wr_req_t             wr_req;
  rd_req_t             rd_req;
  quad_t               quad_rd;

  // Combinational helpers of the sequencer.
  logic [NUM_W-1:0]    col_q, row_q;
  logic [LIM_W-1:0]    x_lim, y_lim;
  logic [COORD_W-1:0]  fx_full, fy_full;
  logic [SCALE_W-1:0]  wx0, wx1, wy0, wy1;
  quad_t               qf;
  logic [SUM_W-1:0]    sum;
  logic [NUM_W-1:0]    quot;

  assign in_x   = in_tdata[COORD_W-1:0];
  assign in_y   = in_tdata[2*COORD_W-1:COORD_W];
  assign in_pix = in_tdata[2*COORD_W+PIX_W-1:2*COORD_W];

  // The block takes a new item only between queries; loads never leave idle.
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign s_eff     = eff_scale(scale_r);

  // Loads go straight into the banks at the accepting edge; out-of-image loads are dropped.
  always_comb begin
    wr_req.en   = in_acc && (in_tuser == OP_LOAD)
                  && ((COORD_W+1)'(in_x) < (COORD_W+1)'(IMG_WIDTH))
                  && ((COORD_W+1)'(in_y) < (COORD_W+1)'(IMG_HEIGHT));
    wr_req.col  = in_x[COL_W-1:0];
    wr_req.row  = in_y[ROW_W-1:0];
    wr_req.data = in_pix;
    rd_req.en   = (state_r == ST_FRAC);
    rd_req.col  = col_r;
    rd_req.row  = row_r;
  end

  imgup_banks u_banks (
    .clk (clk),
    .wr  (wr_req),
    .rd  (rd_req),
    .quad(quad_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      mode_r  <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE: scale_r <= cfg_data[SCALE_W-1:0];
        REG_MODE:  mode_r  <= cfg_data[MODE_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    bad_nxt       = bad_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    quad_nxt      = quad_r;
    w_nxt         = w_r;
    m_nxt         = m_r;
    num_nxt       = num_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_bad_nxt   = out_bad_r;

    // Source cell by reciprocal multiplication, and the scaled image bounds.
    col_q   = div_recip(NUM_W'(x_r), recip_lin(s_eff));
    row_q   = div_recip(NUM_W'(y_r), recip_lin(s_eff));
    x_lim   = LIM_W'(IMG_WIDTH) * LIM_W'(s_eff);
    y_lim   = LIM_W'(IMG_HEIGHT) * LIM_W'(s_eff);

    // Remainder is what the quotient times the scale leaves of the coordinate.
    fx_full = x_r - COORD_W'(COORD_W'(col_r) * COORD_W'(s_eff));
    fy_full = y_r - COORD_W'(COORD_W'(row_r) * COORD_W'(s_eff));

    wx1 = SCALE_W'(fx_r);
    wy1 = SCALE_W'(fy_r);
    wx0 = s_eff - wx1;
    wy0 = s_eff - wy1;

    // At the last column the right pair copies the left; then at the last row
    // the lower pair copies the upper.
    qf = quad_rd;
    if (col_r == COL_W'(IMG_WIDTH - 1)) begin
      qf.ur = qf.ul;
      qf.lr = qf.ll;
    end
    if (row_r == ROW_W'(IMG_HEIGHT - 1)) begin
      qf.ll = qf.ul;
      qf.lr = qf.ur;
    end

    sum = SUM_W'(w_r[0] * quad_r.ul) + SUM_W'(w_r[1] * quad_r.ur)
        + SUM_W'(w_r[2] * quad_r.ll) + SUM_W'(w_r[3] * quad_r.lr);
    quot = div_recip(num_r, m_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_QUERY)) begin
          x_nxt     = in_x;
          y_nxt     = in_y;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        col_nxt = col_q[COL_W-1:0];
        row_nxt = row_q[ROW_W-1:0];
        bad_nxt = (LIM_W'(x_r) >= x_lim) || (LIM_W'(y_r) >= y_lim);
        if (bad_nxt) begin
          // No memory access; a zero numerator yields a zero pixel.
          num_nxt   = '0;
          m_nxt     = recip_lin(4'd1);
          state_nxt = ST_NORM;
        end else begin
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC: begin
        fx_nxt    = fx_full[FRAC_W-1:0];
        fy_nxt    = fy_full[FRAC_W-1:0];
        state_nxt = ST_WGT;
      end
      ST_WGT: begin
        quad_nxt = qf;
        for (int i = 0; i < 4; i++) begin
          w_nxt[i] = '0;
        end
        unique case (mode_r)
          MODE_BILINEAR: begin
            w_nxt[0] = WGT_W'(WGT_W'(wx0) * WGT_W'(wy0));
            w_nxt[1] = WGT_W'(WGT_W'(wx1) * WGT_W'(wy0));
            w_nxt[2] = WGT_W'(WGT_W'(wx0) * WGT_W'(wy1));
            w_nxt[3] = WGT_W'(WGT_W'(wx1) * WGT_W'(wy1));
            m_nxt    = recip_sq(s_eff);
          end
          MODE_HORIZ: begin
            w_nxt[0] = WGT_W'(wx0);
            w_nxt[1] = WGT_W'(wx1);
            m_nxt    = recip_lin(s_eff);
          end
          MODE_VERT: begin
            w_nxt[0] = WGT_W'(wy0);
            w_nxt[2] = WGT_W'(wy1);
            m_nxt    = recip_lin(s_eff);
          end
          MODE_MIDPOINT: begin
            w_nxt[0] = WGT_W'(1);
            if (fx_r == '0 && fy_r == '0) begin
              m_nxt = recip_lin(4'd1);
            end else if (fy_r == '0) begin
              w_nxt[1] = WGT_W'(1);
              m_nxt    = recip_lin(4'd2);
            end else if (fx_r == '0) begin
              w_nxt[2] = WGT_W'(1);
              m_nxt    = recip_lin(4'd2);
            end else begin
              w_nxt[1] = WGT_W'(1);
              w_nxt[2] = WGT_W'(1);
              w_nxt[3] = WGT_W'(1);
              m_nxt    = recip_lin(4'd4);
            end
          end
          default: ;
        endcase
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        num_nxt   = sum[NUM_W-1:0];
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        // Wait here while the output register still holds an untaken result.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = quot[PIX_W-1:0];
          out_bad_nxt   = bad_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    bad_r     <= bad_nxt;
    fx_r      <= fx_nxt;
    fy_r      <= fy_nxt;
    quad_r    <= quad_nxt;
    w_r       <= w_nxt;
    m_r       <= m_nxt;
    num_r     <= num_nxt;
    out_pix_r <= out_pix_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_bad_r;

  // Each bank has one port, so a load must never meet a neighborhood read.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_req.en && rd_req.en))
    else $error("bank write and read in the same cycle");

  // An out-of-range query always reports a zero pixel.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("flagged result carries a nonzero pixel");

  // A query holds off further items while it is in progress.
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_QUERY)) |=> !in_tready)
    else $error("item accepted while a query is in progress");

  // Read data is consumed in the cycle after the read is issued.
  a_read_to_wgt: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req.en |=> (state_r == ST_WGT))
    else $error("bank read data not consumed on the following cycle");

endmodule
